@@ src/mbr_pkg.sv @@
`default_nettype none

package mbr_pkg;

  // Default sizes of the registry.
  localparam int MAX_ENDPOINTS_DEF = 16;
  localparam int QUEUE_DEPTH_DEF   = 32;

  // Fixed field widths of a word.
  localparam int WORD_W     = 64;
  localparam int TOP_W      = 56;
  localparam int NAME_BYTES = 31;
  localparam int NAME_W     = 8 * NAME_BYTES;

  // Operation codes.
  typedef enum logic [1:0] {
    OP_REGISTER = 2'd0,
    OP_LOOKUP   = 2'd1,
    OP_POST     = 2'd2,
    OP_POLL     = 2'd3
  } op_t;

  // Control sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_ACT,
    ST_QREAD,
    ST_RESP
  } state_t;

endpackage

`default_nettype wire

@@ src/mbr_if.sv @@
`default_nettype none

// Request channel: one operation word.
interface mbr_req_if
  import mbr_pkg::*;
;
  logic                valid;
  logic                ready;
  op_t                 op;
  logic [WORD_W-1:0]   name_word_0;
  logic [WORD_W-1:0]   name_word_1;
  logic [WORD_W-1:0]   name_word_2;
  logic [TOP_W-1:0]    name_word_3;
  logic [WORD_W-1:0]   data_in;

  modport source (
    output valid, op, name_word_0, name_word_1, name_word_2, name_word_3, data_in,
    input  ready
  );
  modport sink (
    input  valid, op, name_word_0, name_word_1, name_word_2, name_word_3, data_in,
    output ready
  );
endinterface

// Response channel: one result word.
interface mbr_rsp_if
  import mbr_pkg::*;
;
  logic              valid;
  logic              ready;
  logic              ok;
  logic [WORD_W-1:0] data_out;

  modport source (
    output valid, ok, data_out,
    input  ready
  );
  modport sink (
    input  valid, ok, data_out,
    output ready
  );
endinterface

`default_nettype wire

@@ src/mbr_ep_mem.sv @@
`default_nettype none

// Endpoint table: name, id, queue head and queue fill per endpoint.
module mbr_ep_mem
  import mbr_pkg::*;
#(
  parameter int DEPTH = MAX_ENDPOINTS_DEF,
  parameter int AW    = 4,
  parameter int HW    = 5,
  parameter int FW    = 6
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [AW-1:0]     waddr,
  input  wire logic [NAME_W-1:0] wname,
  input  wire logic [WORD_W-1:0] wid,
  input  wire logic [HW-1:0]     whead,
  input  wire logic [FW-1:0]     wfill,
  input  wire logic              re,
  input  wire logic [AW-1:0]     raddr,
  output logic      [NAME_W-1:0] rname,
  output logic      [WORD_W-1:0] rid,
  output logic      [HW-1:0]     rhead,
  output logic      [FW-1:0]     rfill
);

  localparam int ENT_W = NAME_W + WORD_W + HW + FW;

  logic [ENT_W-1:0] mem [DEPTH];
  logic [ENT_W-1:0] rd_word;

  // One write port; the read word is registered and held while re is low.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= {wname, wid, whead, wfill};
    end
    if (re) begin
      rd_word <= mem[raddr];
    end
  end

  assign {rname, rid, rhead, rfill} = rd_word;

endmodule

`default_nettype wire

@@ src/mbr_queue_mem.sv @@
`default_nettype none

// Shared queue storage: every endpoint owns a contiguous slice of slots.
module mbr_queue_mem
  import mbr_pkg::*;
#(
  parameter int DEPTH = MAX_ENDPOINTS_DEF * QUEUE_DEPTH_DEF,
  parameter int AW    = 9
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [AW-1:0]     waddr,
  input  wire logic [WORD_W-1:0] wdata,
  input  wire logic              re,
  input  wire logic [AW-1:0]     raddr,
  output logic      [WORD_W-1:0] rdata
);

  logic [WORD_W-1:0] mem [DEPTH];

  // Single write port, registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ src/named_mailbox_registry_unit.sv @@
`default_nettype none

// Channel  Dir  Payload                                  Handshake
// req      in   op, name_word_0..3, data_in              valid/ready
// rsp      out  ok, data_out                             valid/ready
//
// One operation is in flight at a time. From acceptance it runs through the
// name search, the action step, a queue read for a successful poll, and the
// response step; the name search reads one table entry per cycle. Reset
// clears the endpoint count and the control state; the memories need no
// clearing pass. A stalled response waits in the output register while the
// next request is accepted.
module named_mailbox_registry_unit
  import mbr_pkg::*;
#(
  parameter int MAX_ENDPOINTS = MAX_ENDPOINTS_DEF,
  parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst,
  mbr_req_if.sink    req,
  mbr_rsp_if.source  rsp
);

  localparam int EW    = (MAX_ENDPOINTS > 1) ? $clog2(MAX_ENDPOINTS) : 1;
  localparam int CNT_W = $clog2(MAX_ENDPOINTS + 1);
  localparam int HW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FW    = $clog2(QUEUE_DEPTH + 1);
  localparam int QTOT  = MAX_ENDPOINTS * QUEUE_DEPTH;
  localparam int QAW   = (QTOT > 1) ? $clog2(QTOT) : 1;

  // Clear every byte after the first zero byte so names compare as strings.
  function automatic logic [NAME_W-1:0] canon_name(input logic [NAME_W-1:0] raw);
    logic [NAME_W-1:0] res;
    logic              ended;
    res   = raw;
    ended = 1'b0;
    for (int k = 0; k < NAME_BYTES; k++) begin
      if (ended) begin
        res[8*k +: 8] = 8'h00;
      end else if (raw[8*k +: 8] == 8'h00) begin
        ended = 1'b1;
      end
    end
    return res;
  endfunction

  // Slot address inside the shared queue memory.
  function automatic logic [QAW-1:0] qaddr(input logic [EW-1:0] ep,
                                           input logic [HW-1:0] slot);
    return QAW'(ep) * QAW'(QUEUE_DEPTH) + QAW'(slot);
  endfunction

  state_t state, state_next;

  op_t               cur_op;
  logic [NAME_W-1:0] cur_name;
  logic [WORD_W-1:0] cur_data;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  sidx;
  logic              cmp_valid;
  logic [EW-1:0]     cmp_idx;
  logic              hit;
  logic [EW-1:0]     ep_sel;
  logic              res_ok;
  logic [WORD_W-1:0] res_data;
  logic              out_valid;
  logic              out_ok;
  logic [WORD_W-1:0] out_data;

  logic              accept;
  logic              match;
  logic              issue;
  logic              full;
  logic              q_full;
  logic              q_empty;
  logic [FW:0]       slot_sum;
  logic [HW-1:0]     tail;
  logic [HW-1:0]     head_inc;

  logic              ep_we;
  logic [EW-1:0]     ep_waddr;
  logic [NAME_W-1:0] ep_wname;
  logic [WORD_W-1:0] ep_wid;
  logic [HW-1:0]     ep_whead;
  logic [FW-1:0]     ep_wfill;
  logic [NAME_W-1:0] ep_rd_name;
  logic [WORD_W-1:0] ep_rd_id;
  logic [HW-1:0]     ep_rd_head;
  logic [FW-1:0]     ep_rd_fill;

  logic              q_we;
  logic [QAW-1:0]    q_waddr;
  logic              q_re;
  logic [QAW-1:0]    q_raddr;
  logic [WORD_W-1:0] q_rdata;

  logic              act_ok;
  logic [WORD_W-1:0] act_data;
  logic              count_inc;
  logic              rsp_load;

  // Endpoint table and queue storage.
  mbr_ep_mem #(
    .DEPTH (MAX_ENDPOINTS),
    .AW    (EW),
    .HW    (HW),
    .FW    (FW)
  ) u_ep_mem (
    .clk   (clk),
    .we    (ep_we),
    .waddr (ep_waddr),
    .wname (ep_wname),
    .wid   (ep_wid),
    .whead (ep_whead),
    .wfill (ep_wfill),
    .re    (issue),
    .raddr (sidx[EW-1:0]),
    .rname (ep_rd_name),
    .rid   (ep_rd_id),
    .rhead (ep_rd_head),
    .rfill (ep_rd_fill)
  );

  mbr_queue_mem #(
    .DEPTH (QTOT),
    .AW    (QAW)
  ) u_queue_mem (
    .clk   (clk),
    .we    (q_we),
    .waddr (q_waddr),
    .wdata (cur_data),
    .re    (q_re),
    .raddr (q_raddr),
    .rdata (q_rdata)
  );

  // Handshakes.
  assign accept       = req.valid && req.ready;
  assign req.ready    = (state == ST_IDLE);
  assign rsp.valid    = out_valid;
  assign rsp.ok       = out_ok;
  assign rsp.data_out = out_data;

  // Search: one entry read per cycle, compared in the next cycle.
  assign match = (state == ST_SEARCH) && cmp_valid && (ep_rd_name == cur_name);
  assign issue = (state == ST_SEARCH) && (sidx < count) && !match;
  assign full  = (count == CNT_W'(MAX_ENDPOINTS));

  // Queue pointer arithmetic on the matched entry.
  assign q_full   = (ep_rd_fill >= FW'(QUEUE_DEPTH));
  assign q_empty  = (ep_rd_fill == '0);
  assign slot_sum = (FW+1)'(ep_rd_head) + (FW+1)'(ep_rd_fill);
  assign tail     = (slot_sum >= (FW+1)'(QUEUE_DEPTH)) ?
                    HW'(slot_sum - (FW+1)'(QUEUE_DEPTH)) : HW'(slot_sum);
  assign head_inc = (ep_rd_head == HW'(QUEUE_DEPTH - 1)) ? '0 : ep_rd_head + HW'(1);

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (match || !issue) begin
          state_next = ST_ACT;
        end
      end
      ST_ACT: begin
        if (cur_op == OP_POLL && hit && !q_empty) begin
          state_next = ST_QREAD;
        end else begin
          state_next = ST_RESP;
        end
      end
      ST_QREAD: begin
        state_next = ST_RESP;
      end
      ST_RESP: begin
        if (rsp_load) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Memory controls and results of the operation step.
  always_comb begin
    ep_we     = 1'b0;
    ep_waddr  = ep_sel;
    ep_wname  = cur_name;
    ep_wid    = ep_rd_id;
    ep_whead  = ep_rd_head;
    ep_wfill  = ep_rd_fill;
    q_we      = 1'b0;
    q_waddr   = qaddr(ep_sel, tail);
    q_re      = 1'b0;
    q_raddr   = qaddr(ep_sel, ep_rd_head);
    act_ok    = 1'b0;
    act_data  = '0;
    count_inc = 1'b0;
    rsp_load  = 1'b0;
    case (state)
      ST_ACT: begin
        case (cur_op)
          OP_REGISTER: begin
            if (hit) begin
              ep_we  = 1'b1;
              ep_wid = cur_data;
              act_ok = 1'b1;
            end else if (!full) begin
              ep_we     = 1'b1;
              ep_waddr  = count[EW-1:0];
              ep_wid    = cur_data;
              ep_whead  = '0;
              ep_wfill  = '0;
              count_inc = 1'b1;
              act_ok    = 1'b1;
            end
          end
          OP_LOOKUP: begin
            if (hit) begin
              act_ok   = 1'b1;
              act_data = ep_rd_id;
            end
          end
          OP_POST: begin
            if (hit) begin
              if (!q_full) begin
                q_we     = 1'b1;
                ep_we    = 1'b1;
                ep_wfill = ep_rd_fill + FW'(1);
                act_ok   = 1'b1;
              end
            end else if (!full) begin
              // A new endpoint takes the word in its first slot.
              ep_we     = 1'b1;
              ep_waddr  = count[EW-1:0];
              ep_wid    = '0;
              ep_whead  = '0;
              ep_wfill  = FW'(1);
              q_we      = 1'b1;
              q_waddr   = qaddr(count[EW-1:0], '0);
              count_inc = 1'b1;
              act_ok    = 1'b1;
            end
          end
          OP_POLL: begin
            if (hit && !q_empty) begin
              q_re     = 1'b1;
              ep_we    = 1'b1;
              ep_whead = head_inc;
              ep_wfill = ep_rd_fill - FW'(1);
              act_ok   = 1'b1;
            end
          end
          default: begin
            act_ok = 1'b0;
          end
        endcase
      end
      ST_RESP: begin
        rsp_load = !out_valid || rsp.ready;
      end
      default: begin
        rsp_load = 1'b0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      cmp_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cmp_valid <= issue;
      if (count_inc) begin
        count <= count + CNT_W'(1);
      end
      if (rsp_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Operation and result registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      cur_op   <= req.op;
      cur_name <= canon_name({req.name_word_3, req.name_word_2,
                              req.name_word_1, req.name_word_0});
      cur_data <= req.data_in;
      sidx     <= '0;
    end else if (issue) begin
      sidx <= sidx + CNT_W'(1);
    end
    cmp_idx <= sidx[EW-1:0];
    if (state == ST_SEARCH) begin
      hit    <= match;
      ep_sel <= match ? cmp_idx : count[EW-1:0];
    end
    if (state == ST_ACT) begin
      res_ok   <= act_ok;
      res_data <= act_data;
    end
    if (state == ST_QREAD) begin
      res_data <= q_rdata;
    end
    if (rsp_load) begin
      out_ok   <= res_ok;
      out_data <= res_data;
    end
  end

  // The endpoint count never passes the table size.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_ENDPOINTS))
    else $error("endpoint count beyond table size");

  // The queue memory is never read and written in the same cycle.
  a_queue_port: assert property (@(posedge clk) disable iff (rst)
    !(q_we && q_re))
    else $error("queue read and write collide");

  // A response appears only after the response step.
  a_rsp_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_RESP)
    else $error("response loaded outside the response step");

  // A matched entry never reports more words than its queue holds.
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ACT && hit) |-> ep_rd_fill <= FW'(QUEUE_DEPTH))
    else $error("queue fill beyond depth");

endmodule

`default_nettype wire

@@ bench/mbx_registry_checker.sv @@
`default_nettype none

// Watches both channels, predicts every response from its own copy of the
// registry, and compares each accepted response word with the oldest prediction.
module mbx_registry_checker
  import mbr_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  mbr_req_if    req,
  mbr_rsp_if    rsp,
  output int    pending,
  output int    errors
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic              ok;
    logic [WORD_W-1:0] data;
  } mbx_reply_t;

  // Shadow copy of the registry.
  int                live_count = 0;
  logic [NAME_W-1:0] ep_name [MAX_ENDPOINTS_DEF];
  logic [WORD_W-1:0] ep_id   [MAX_ENDPOINTS_DEF];
  logic [WORD_W-1:0] ep_fifo [MAX_ENDPOINTS_DEF][$];

  // Replies predicted but not yet seen on the response channel.
  mbx_reply_t due_replies [$];
  int         outstanding = 0;
  int         mismatches  = 0;

  assign pending = outstanding;
  assign errors  = mismatches;

  task automatic flag_mismatch(input string what);
    $display("%0t ns: mismatch: %s", $time, what);
    mismatches++;
  endtask

  // A name ends at its first zero byte; everything after it is ignored.
  function automatic logic [NAME_W-1:0] trim_name(input logic [NAME_W-1:0] raw);
    logic [NAME_W-1:0] t;
    bit                ended;
    t     = '0;
    ended = 1'b0;
    for (int k = 0; k < NAME_BYTES; k++) begin
      if (raw[8*k +: 8] == 8'h00) ended = 1'b1;
      if (!ended) t[8*k +: 8] = raw[8*k +: 8];
    end
    return t;
  endfunction

  function automatic int find_endpoint(input logic [NAME_W-1:0] nm);
    for (int i = 0; i < live_count; i++) begin
      if (ep_name[i] == nm) return i;
    end
    return -1;
  endfunction

  // Find the endpoint, or create it while the table has room.
  function automatic int claim_endpoint(input logic [NAME_W-1:0] nm);
    int e;
    e = find_endpoint(nm);
    if (e >= 0) return e;
    if (live_count >= MAX_ENDPOINTS_DEF) return -1;
    e = live_count;
    ep_name[e] = nm;
    ep_id[e]   = '0;
    ep_fifo[e].delete();
    live_count++;
    return e;
  endfunction

  // Apply one request word to the shadow registry and return its reply.
  function automatic mbx_reply_t predict_reply(input op_t op_code,
                                               input logic [NAME_W-1:0] raw_name,
                                               input logic [WORD_W-1:0] payload);
    mbx_reply_t        r;
    logic [NAME_W-1:0] nm;
    int                e;
    r  = '0;
    nm = trim_name(raw_name);
    case (op_code)
      OP_REGISTER: begin
        e = claim_endpoint(nm);
        if (e >= 0) begin
          ep_id[e] = payload;
          r.ok     = 1'b1;
        end
      end
      OP_LOOKUP: begin
        e = find_endpoint(nm);
        if (e >= 0) begin
          r.ok   = 1'b1;
          r.data = ep_id[e];
        end
      end
      OP_POST: begin
        e = claim_endpoint(nm);
        if (e >= 0 && ep_fifo[e].size() < QUEUE_DEPTH_DEF) begin
          ep_fifo[e].push_back(payload);
          r.ok = 1'b1;
        end
      end
      default: begin
        e = find_endpoint(nm);
        if (e >= 0 && ep_fifo[e].size() > 0) begin
          r.ok   = 1'b1;
          r.data = ep_fifo[e].pop_front();
        end
      end
    endcase
    return r;
  endfunction

  // Responses are checked before new requests are predicted; a request
  // accepted in this cycle cannot have answered yet.
  always @(posedge clk) begin : watch
    mbx_reply_t want;
    if (!rst) begin
      if (rsp.valid && rsp.ready) begin
        if (due_replies.size() == 0) begin
          flag_mismatch($sformatf("response word ok=%0b data=%h with nothing outstanding",
                                  rsp.ok, rsp.data_out));
        end else begin
          want = due_replies.pop_front();
          if (rsp.ok !== want.ok)
            flag_mismatch($sformatf("ok is %0b, expected %0b", rsp.ok, want.ok));
          if (rsp.data_out !== want.data)
            flag_mismatch($sformatf("data_out is %h, expected %h", rsp.data_out, want.data));
        end
      end
      if (req.valid && req.ready) begin
        due_replies.push_back(predict_reply(req.op,
            {req.name_word_3, req.name_word_2, req.name_word_1, req.name_word_0},
            req.data_in));
      end
    end
    outstanding <= due_replies.size();
  end

endmodule

`default_nettype wire

@@ bench/tb_named_mailbox_registry_unit.sv @@
`default_nettype none

module tb_named_mailbox_registry_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import mbr_pkg::*;

  localparam int POOL_SIZE    = 20;
  localparam int RANDOM_ITEMS = 1300;
  localparam int IDLE_LIMIT   = 2000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   pending;
  int   errors;

  mbr_req_if req_ch ();
  mbr_rsp_if rsp_ch ();

  named_mailbox_registry_unit dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  mbx_registry_checker chk (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .rsp     (rsp_ch),
    .pending (pending),
    .errors  (errors)
  );

  always #4 clk = ~clk;

  logic [NAME_W-1:0] name_pool [POOL_SIZE];
  bit                steady    = 1'b0;
  logic              rsp_taken = 1'b0;
  int                sent      = 0;
  int                idle_cycles = 0;

  // Note response handshakes, and stop the run if nothing moves for too long.
  always @(posedge clk) begin
    rsp_taken <= rsp_ch.valid && rsp_ch.ready;
    if (!rst) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Receiver: after each response word, hold ready low for a random stretch.
  initial begin
    int hold;
    hold = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (rst) begin
        rsp_ch.ready <= 1'b0;
      end else if (rsp_taken) begin
        hold = steady ? 0 : $urandom_range(0, 10);
        rsp_ch.ready <= (hold == 0);
        if (hold > 0) hold = hold - 1;
      end else if (hold > 0) begin
        rsp_ch.ready <= 1'b0;
        hold = hold - 1;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  function automatic logic [WORD_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Fill the bytes after the terminating zero with junk.
  function automatic logic [NAME_W-1:0] smear_tail(input logic [NAME_W-1:0] nm);
    logic [NAME_W-1:0] r;
    int                len;
    r   = nm;
    len = NAME_BYTES;
    for (int k = NAME_BYTES - 1; k >= 0; k--) begin
      if (nm[8*k +: 8] == 8'h00) len = k;
    end
    for (int k = len + 1; k < NAME_BYTES; k++) r[8*k +: 8] = 8'($urandom);
    return r;
  endfunction

  function automatic logic [NAME_W-1:0] pooled(input int slot);
    if ($urandom_range(0, 1) == 0) return smear_tail(name_pool[slot]);
    return name_pool[slot];
  endfunction

  function automatic logic [NAME_W-1:0] noise_name();
    logic [NAME_W-1:0] r;
    for (int k = 0; k < NAME_BYTES; k++) r[8*k +: 8] = 8'($urandom);
    return r;
  endfunction

  // Present one request word after a random gap and wait for acceptance.
  task automatic issue(input op_t op_code, input logic [NAME_W-1:0] nm,
                       input logic [WORD_W-1:0] payload);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      @(negedge clk);
      req_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    req_ch.valid       <= 1'b1;
    req_ch.op          <= op_code;
    req_ch.name_word_0 <= nm[63:0];
    req_ch.name_word_1 <= nm[127:64];
    req_ch.name_word_2 <= nm[191:128];
    req_ch.name_word_3 <= nm[NAME_W-1:192];
    req_ch.data_in     <= payload;
    do @(posedge clk); while (!req_ch.ready);
    sent++;
  endtask

  // Stop sending until every outstanding response has come back.
  task automatic hold_until_drained();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    logic [NAME_W-1:0] nm;
    int                len;
    int                pick;
    int                slot;
    int                burst_len;
    int                idx;
    int                next_regime;

    req_ch.valid       <= 1'b0;
    req_ch.op          <= OP_REGISTER;
    req_ch.name_word_0 <= '0;
    req_ch.name_word_1 <= '0;
    req_ch.name_word_2 <= '0;
    req_ch.name_word_3 <= '0;
    req_ch.data_in     <= '0;

    // Name pool: the empty name, an all-ones full-length name, a one-byte
    // name, a full-length random name, and random lengths for the rest.
    for (int p = 0; p < POOL_SIZE; p++) begin
      case (p)
        0:       len = 0;
        1, 3:    len = NAME_BYTES;
        2:       len = 1;
        default: len = $urandom_range(1, NAME_BYTES);
      endcase
      nm = '0;
      for (int k = 0; k < len; k++) nm[8*k +: 8] = (p == 1) ? 8'hFF : 8'($urandom_range(1, 255));
      name_pool[p] = nm;
    end

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed words: unknown names, the empty name, junk after the
    // terminator, queue order, empty queue, new endpoint id, id extremes.
    issue(OP_LOOKUP,   name_pool[0], rand64());
    issue(OP_POLL,     name_pool[1], rand64());
    issue(OP_REGISTER, name_pool[0], '1);
    issue(OP_LOOKUP,   {{(NAME_W - 8){1'b1}}, 8'h00}, rand64());
    issue(OP_POST,     name_pool[1], '0);
    issue(OP_POST,     name_pool[1], '1);
    issue(OP_POLL,     name_pool[1], rand64());
    issue(OP_POLL,     name_pool[1], rand64());
    issue(OP_POLL,     name_pool[1], rand64());
    issue(OP_LOOKUP,   name_pool[1], rand64());
    issue(OP_REGISTER, name_pool[1], 64'h8000_0000_0000_0001);
    issue(OP_LOOKUP,   smear_tail(name_pool[1]), rand64());
    issue(OP_REGISTER, name_pool[2], '0);
    issue(OP_POST,     smear_tail(name_pool[2]), rand64());
    issue(OP_LOOKUP,   noise_name(), rand64());
    issue(OP_POLL,     noise_name(), rand64());
    issue(OP_REGISTER, name_pool[3], '1);
    issue(OP_LOOKUP,   name_pool[3], rand64());
    issue(OP_POLL,     name_pool[0], rand64());
    issue(OP_POST,     name_pool[0], rand64());
    issue(OP_POLL,     smear_tail(name_pool[0]), rand64());
    issue(OP_LOOKUP,   name_pool[2], rand64());
    hold_until_drained();

    // Random words: mostly pool names so that endpoints are hit, with
    // queue floods, register/lookup pairs, near misses and pure noise.
    sent        = 0;
    next_regime = 0;
    while (sent < RANDOM_ITEMS) begin
      if (sent >= next_regime) begin
        steady      = ($urandom_range(0, 3) == 0);
        next_regime = sent + $urandom_range(40, 120);
        if ($urandom_range(0, 3) == 0) hold_until_drained();
      end
      pick = $urandom_range(0, 39);
      slot = $urandom_range(0, POOL_SIZE - 1);
      if (pick < 22) begin
        issue(op_t'($urandom_range(0, 3)), pooled(slot), rand64());
      end else if (pick < 24) begin
        // Post a burst of 28 to 34 words, up to or past the queue depth, then poll once more than posted.
        burst_len = $urandom_range(28, 34);
        repeat (burst_len) issue(OP_POST, pooled(slot), rand64());
        repeat (burst_len + 1) issue(OP_POLL, pooled(slot), rand64());
      end else if (pick < 31) begin
        issue(OP_REGISTER, pooled(slot), rand64());
        issue(OP_LOOKUP, pooled(slot), rand64());
      end else if (pick < 36) begin
        nm  = name_pool[slot];
        idx = $urandom_range(0, NAME_BYTES - 1);
        nm[8*idx +: 8] = nm[8*idx +: 8] ^ 8'($urandom_range(1, 255));
        issue(op_t'($urandom_range(0, 3)), nm, rand64());
      end else begin
        issue(op_t'($urandom_range(0, 3)), noise_name(), rand64());
      end
    end

    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
